// File: hw/rtl/rdip_pkg.sv
// Shared types and constants for the relative decimal integer parser.
// Has no dependencies; the parse core, clamp stage and top level import it.
`default_nettype none

package rdip_pkg;

    localparam int CHAR_W  = 8;
    localparam int MAG_W   = 32;
    localparam int VALUE_W = 32;
    localparam int CNT_W   = 8;
    localparam int CFG_IDX_W = 2;

    // Values the clamp works in: a 32-bit signed base plus a 33-bit signed number.
    localparam int WIDE_W = VALUE_W + 2;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_AT    = 8'h40;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALUE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_VALUE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE     = 2'd2;

    // Snapshot of a finished parse, handed from the parse core to the clamp stage
    typedef struct packed {
        logic             seen_digit;
        logic             relative;
        logic             negative;
        logic [MAG_W-1:0] magnitude;
        logic [CNT_W-1:0] char_count;
    } rdip_rec_t;

endpackage

`default_nettype wire

// File: hw/rtl/relative_decimal_int_parser_unit.sv
// Relative decimal integer parser top level: config registers, parse core, clamp stage.
// A terminating character passes the character input and record registers before
// out_valid rises. Throughput: one character per cycle unless stalled; stall propagates
// back from the output register through the record register to the input register.
// Reset (rst_n, async, active low): skip phase, no result pending, min_value = -2^31,
// default_value = 0, max_value = 2^31-1. Depends on rdip_pkg, rdip_parse_core, rdip_clamp.
`default_nettype none

module relative_decimal_int_parser_unit
    import rdip_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    // character channel
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [CHAR_W-1:0]       ch,

    // result channel
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic signed [VALUE_W-1:0]    value,
    output logic                         had_digits,
    output logic                         was_relative,
    output logic [CNT_W-1:0]             chars_used,

    // configuration write channel
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [VALUE_W-1:0]      cfg_data
);

    logic signed [VALUE_W-1:0] min_value_reg;
    logic signed [VALUE_W-1:0] default_value_reg;
    logic signed [VALUE_W-1:0] max_value_reg;

    logic       rec_valid;
    logic       rec_ready;
    rdip_rec_t  rec;

    // Configuration writes are always accepted; unknown indexes drop.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_value_reg     <= {1'b1, {(VALUE_W-1){1'b0}}};
            default_value_reg <= '0;
            max_value_reg     <= {1'b0, {(VALUE_W-1){1'b1}}};
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MIN_VALUE:     min_value_reg     <= signed'(cfg_data);
                CFG_DEFAULT_VALUE: default_value_reg <= signed'(cfg_data);
                CFG_MAX_VALUE:     max_value_reg     <= signed'(cfg_data);
                default:           ;
            endcase
        end
    end

    // Stage 1/2: register the character, advance the parse state, hand off a record
    // on every transfer that finishes a parse.
    rdip_parse_core u_parse_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .ch        (ch),
        .rec_valid (rec_valid),
        .rec       (rec),
        .rec_ready (rec_ready)
    );

    // Stage 3: default, relative add and clamp into the output register.
    rdip_clamp u_clamp (
        .clk           (clk),
        .rst_n         (rst_n),
        .rec_valid     (rec_valid),
        .rec           (rec),
        .rec_ready     (rec_ready),
        .min_value     (min_value_reg),
        .default_value (default_value_reg),
        .max_value     (max_value_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .value         (value),
        .had_digits    (had_digits),
        .was_relative  (was_relative),
        .chars_used    (chars_used)
    );

endmodule

`default_nettype wire

// File: hw/rtl/rdip_parse_core.sv
// Character input register and parse state; emits a finished-parse record.
// Depends on rdip_pkg.
`default_nettype none

module rdip_parse_core
    import rdip_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [CHAR_W-1:0] ch,
    output logic                   rec_valid,
    output rdip_rec_t              rec,
    input  wire logic              rec_ready
);

    logic              ch_valid_reg;
    logic [CHAR_W-1:0] ch_reg;

    logic              in_digits_reg, in_digits_next;
    logic              negative_reg, negative_next;
    logic              relative_reg, relative_next;
    logic              seen_digit_reg, seen_digit_next;
    logic [MAG_W-1:0]  magnitude_reg, magnitude_next;
    logic [CNT_W-1:0]  char_count_reg, char_count_next;

    logic              rec_valid_reg, rec_valid_next;
    rdip_rec_t         rec_reg, rec_next;

    logic              take;
    logic              accept;
    logic              is_digit;
    logic [MAG_W+3:0]  mag_prod;
    logic [MAG_W-1:0]  mag_sat;
    logic [CNT_W-1:0]  cnt_inc;

    assign take     = ch_valid_reg && (!rec_valid_reg || rec_ready);
    assign in_stall = ch_valid_reg && !take;
    assign accept   = in_valid && !in_stall;

    assign is_digit = ch_reg inside {[CH_ZERO:CH_NINE]};

    // magnitude * 10 + digit as (m << 3) + (m << 1) + d, saturating
    assign mag_prod = {1'b0, magnitude_reg, 3'b000} + {3'b000, magnitude_reg, 1'b0}
                    + {{(MAG_W){1'b0}}, ch_reg[3:0]};
    assign mag_sat  = (mag_prod[MAG_W+3:MAG_W] != 4'd0) ? MAG_MAX : mag_prod[MAG_W-1:0];
    assign cnt_inc  = (char_count_reg == CNT_MAX) ? char_count_reg : char_count_reg + 1'b1;

    always_comb
    begin
        in_digits_next  = in_digits_reg;
        negative_next   = negative_reg;
        relative_next   = relative_reg;
        seen_digit_next = seen_digit_reg;
        magnitude_next  = magnitude_reg;
        char_count_next = char_count_reg;
        rec_valid_next  = rec_valid_reg && !rec_ready;
        rec_next        = rec_reg;

        if (take)
        begin
            rec_valid_next        = 1'b0;
            rec_next.seen_digit   = seen_digit_reg;
            rec_next.relative     = relative_reg;
            rec_next.negative     = negative_reg;
            rec_next.magnitude    = magnitude_reg;
            rec_next.char_count   = char_count_reg;

            if (ch_reg == CH_NUL)
            begin
                // end of string: emit and clear, NUL is not counted
                rec_valid_next  = 1'b1;
                in_digits_next  = 1'b0;
                negative_next   = 1'b0;
                relative_next   = 1'b0;
                seen_digit_next = 1'b0;
                magnitude_next  = '0;
                char_count_next = '0;
            end
            else if (is_digit)
            begin
                in_digits_next  = 1'b1;
                seen_digit_next = 1'b1;
                magnitude_next  = mag_sat;
                char_count_next = cnt_inc;
            end
            else if (!in_digits_reg)
            begin
                char_count_next = cnt_inc;
                if (ch_reg >= CH_AT)
                begin
                    // high character while skipping: counted, consumed, gives default
                    rec_valid_next      = 1'b1;
                    rec_next.char_count = cnt_inc;
                    negative_next       = 1'b0;
                    relative_next       = 1'b0;
                    magnitude_next      = '0;
                    char_count_next     = '0;
                end
                else
                begin
                    if (ch_reg == CH_PLUS || ch_reg == CH_MINUS)
                        relative_next = 1'b1;
                    if (ch_reg == CH_MINUS)
                        negative_next = 1'b1;
                end
            end
            else
            begin
                // terminator after digits: emit; a low character opens the next parse
                rec_valid_next  = 1'b1;
                in_digits_next  = 1'b0;
                seen_digit_next = 1'b0;
                magnitude_next  = '0;
                negative_next   = 1'b0;
                relative_next   = 1'b0;
                char_count_next = '0;
                if (ch_reg < CH_AT)
                begin
                    char_count_next = {{(CNT_W-1){1'b0}}, 1'b1};
                    relative_next   = (ch_reg == CH_PLUS) || (ch_reg == CH_MINUS);
                    negative_next   = (ch_reg == CH_MINUS);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_valid_reg   <= 1'b0;
            in_digits_reg  <= 1'b0;
            negative_reg   <= 1'b0;
            relative_reg   <= 1'b0;
            seen_digit_reg <= 1'b0;
            magnitude_reg  <= '0;
            char_count_reg <= '0;
            rec_valid_reg  <= 1'b0;
        end
        else
        begin
            ch_valid_reg   <= accept || (ch_valid_reg && !take);
            in_digits_reg  <= in_digits_next;
            negative_reg   <= negative_next;
            relative_reg   <= relative_next;
            seen_digit_reg <= seen_digit_next;
            magnitude_reg  <= magnitude_next;
            char_count_reg <= char_count_next;
            rec_valid_reg  <= rec_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            ch_reg <= ch;
        rec_reg <= rec_next;
    end

    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

endmodule

`default_nettype wire

// File: hw/rtl/rdip_clamp.sv
// Result stage: applies default, relative offset and clamp, holds the output register.
// Depends on rdip_pkg.
`default_nettype none

module rdip_clamp
    import rdip_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      rec_valid,
    input  wire rdip_rec_t                 rec,
    output logic                           rec_ready,
    input  wire logic signed [VALUE_W-1:0] min_value,
    input  wire logic signed [VALUE_W-1:0] default_value,
    input  wire logic signed [VALUE_W-1:0] max_value,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic signed [VALUE_W-1:0]      value,
    output logic                           had_digits,
    output logic                           was_relative,
    output logic [CNT_W-1:0]               chars_used
);

    logic                         out_valid_reg;
    logic signed [VALUE_W-1:0]    value_reg, value_next;
    logic                         had_digits_reg;
    logic                         was_relative_reg;
    logic [CNT_W-1:0]             chars_used_reg;

    logic signed [WIDE_W-1:0]     mag_ext;
    logic signed [WIDE_W-1:0]     num;
    logic signed [WIDE_W-1:0]     def_ext;
    logic signed [WIDE_W-1:0]     min_ext;
    logic signed [WIDE_W-1:0]     max_ext;
    logic signed [WIDE_W-1:0]     raw;
    logic                         load;

    assign rec_ready = !out_valid_reg || !out_stall;
    assign load      = rec_valid && rec_ready;

    always_comb
    begin
        mag_ext = signed'({2'b00, rec.magnitude});
        num     = rec.negative ? -mag_ext : mag_ext;
        def_ext = WIDE_W'(default_value);
        min_ext = WIDE_W'(min_value);
        max_ext = WIDE_W'(max_value);

        if (!rec.seen_digit)
            raw = def_ext;
        else if (rec.relative)
            raw = def_ext + num;
        else
            raw = num;

        // with reversed bounds, a value below the lower bound gives it, any other the upper bound
        if (raw < min_ext)
            value_next = min_value;
        else if (raw > max_ext)
            value_next = max_value;
        else
            value_next = raw[VALUE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (rec_ready)
            out_valid_reg <= rec_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg        <= value_next;
            had_digits_reg   <= rec.seen_digit;
            was_relative_reg <= rec.relative;
            chars_used_reg   <= rec.char_count;
        end
    end

    assign out_valid    = out_valid_reg;
    assign value        = value_reg;
    assign had_digits   = had_digits_reg;
    assign was_relative = was_relative_reg;
    assign chars_used   = chars_used_reg;

endmodule

`default_nettype wire

// File: dv/rdip_scoreboard_pkg.sv
// Scoreboard for the relative decimal integer parser: predicts each parse result
// from the characters accepted and checks the results that come back.
// Depends on rdip_pkg for widths, character codes and register indexes.
`timescale 1ns / 100ps

package rdip_scoreboard_pkg;

    import rdip_pkg::*;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      had_digits;
        logic                      was_relative;
        logic [CNT_W-1:0]          chars_used;
    } parse_result_t;

    class int_parse_scoreboard;

        // register copies
        logic signed [VALUE_W-1:0] lower_bound;
        logic signed [VALUE_W-1:0] base_value;
        logic signed [VALUE_W-1:0] upper_bound;

        // parse state
        bit               digit_phase;
        bit               minus_seen;
        bit               sign_seen;
        bit               any_digit;
        bit [MAG_W-1:0]   accum;
        bit [CNT_W-1:0]   consumed;

        parse_result_t    awaited_results[$];
        int unsigned      mismatches;
        int unsigned      results_checked;

        function new();
            lower_bound = {1'b1, {(VALUE_W-1){1'b0}}};
            base_value  = '0;
            upper_bound = {1'b0, {(VALUE_W-1){1'b1}}};
            mismatches = 0;
            results_checked = 0;
            restart_parse();
        endfunction

        function void restart_parse();
            digit_phase = 1'b0;
            minus_seen  = 1'b0;
            sign_seen   = 1'b0;
            any_digit   = 1'b0;
            accum       = '0;
            consumed    = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [VALUE_W-1:0] data);
            case (idx)
                CFG_MIN_VALUE:     lower_bound = data;
                CFG_DEFAULT_VALUE: base_value  = data;
                CFG_MAX_VALUE:     upper_bound = data;
                default: ;
            endcase
        endfunction

        function int unsigned pending_count();
            return awaited_results.size();
        endfunction

        function void bump_consumed();
            if (consumed != CNT_MAX)
                consumed++;
        endfunction

        function void take_digit(bit [3:0] d);
            bit [63:0] grown;
            grown = {32'd0, accum} * 64'd10 + 64'(d);
            accum = (grown > {32'd0, MAG_MAX}) ? MAG_MAX : grown[MAG_W-1:0];
            any_digit = 1'b1;
            bump_consumed();
        endfunction

        // Apply default and offset, clamp, queue the result and return to the skip phase.
        function void close_parse();
            longint        number;
            longint        outcome;
            parse_result_t r;
            number = longint'({32'd0, accum});
            if (minus_seen)
                number = -number;
            if (!any_digit)
                outcome = longint'(base_value);
            else if (sign_seen)
                outcome = longint'(base_value) + number;
            else
                outcome = number;
            if (outcome < longint'(lower_bound))
                outcome = longint'(lower_bound);
            else if (outcome > longint'(upper_bound))
                outcome = longint'(upper_bound);
            r.value        = outcome[VALUE_W-1:0];
            r.had_digits   = any_digit;
            r.was_relative = sign_seen;
            r.chars_used   = consumed;
            awaited_results.push_back(r);
            restart_parse();
        endfunction

        function void skip_phase_char(logic [CHAR_W-1:0] c);
            if (c >= CH_ZERO && c <= CH_NINE) begin
                digit_phase = 1'b1;
                take_digit(4'(c - CH_ZERO));
                return;
            end
            bump_consumed();
            if (c >= CH_AT) begin
                close_parse();
                return;
            end
            if (c == CH_PLUS)
                sign_seen = 1'b1;
            if (c == CH_MINUS) begin
                sign_seen  = 1'b1;
                minus_seen = 1'b1;
            end
        endfunction

        // Advance the prediction by one accepted character.
        function void note_char(logic [CHAR_W-1:0] c);
            if (c == CH_NUL) begin
                close_parse();
                return;
            end
            if (!digit_phase) begin
                skip_phase_char(c);
                return;
            end
            if (c >= CH_ZERO && c <= CH_NINE) begin
                take_digit(4'(c - CH_ZERO));
                return;
            end
            close_parse();
            if (c < CH_AT)
                skip_phase_char(c);
        endfunction

        function void check_result(logic signed [VALUE_W-1:0] got_value,
                                   logic got_digits, logic got_relative,
                                   logic [CNT_W-1:0] got_used);
            parse_result_t want;
            results_checked++;
            if (awaited_results.size() == 0) begin
                $error("unexpected result: value %0d, no parse outstanding", got_value);
                mismatches++;
                return;
            end
            want = awaited_results.pop_front();
            if (got_value !== want.value) begin
                $error("value mismatch: expected %0d, got %0d", want.value, got_value);
                mismatches++;
            end
            if (got_digits !== want.had_digits) begin
                $error("had_digits mismatch: expected %0b, got %0b",
                       want.had_digits, got_digits);
                mismatches++;
            end
            if (got_relative !== want.was_relative) begin
                $error("was_relative mismatch: expected %0b, got %0b",
                       want.was_relative, got_relative);
                mismatches++;
            end
            if (got_used !== want.chars_used) begin
                $error("chars_used mismatch: expected %0d, got %0d",
                       want.chars_used, got_used);
                mismatches++;
            end
        endfunction

    endclass

endpackage

// File: dv/tb_top.sv
// Top-level testbench for relative_decimal_int_parser_unit: drives characters and
// register writes, paces both channels and checks every result against the scoreboard.
// Depends on rdip_pkg and rdip_scoreboard_pkg.
`timescale 1ns / 100ps

module tb_top;

    import rdip_pkg::*;
    import rdip_scoreboard_pkg::*;

    localparam logic signed [VALUE_W-1:0] INT_LO = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] INT_HI = 32'sh7FFF_FFFF;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned PHASE_CHARS = 140;
    localparam int          NUM_PHASES  = 9;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [CHAR_W-1:0]         ch;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [VALUE_W-1:0] value;
    logic                      had_digits;
    logic                      was_relative;
    logic [CNT_W-1:0]          chars_used;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [VALUE_W-1:0]        cfg_data;

    int_parse_scoreboard sb = new();

    int unsigned send_gap_pct;
    int unsigned recv_stall_pct;
    int unsigned chars_sent;
    int unsigned cfg_writes;
    int unsigned quiet_cycles = 0;

    // Directed opening: NUL with nothing parsed, '@' and 0xFF in the skip phase,
    // repeated signs ending in a digit-phase terminator that starts the next parse,
    // a high terminator that gets dropped, a saturating run of nines, '?' then 0x80.
    logic [CHAR_W-1:0] directed_text [23] = '{
        CH_NUL, CH_AT, 8'hFF,
        CH_PLUS, CH_MINUS, CH_NINE, 8'h2C,
        CH_ZERO, 8'h41,
        CH_NINE, CH_NINE, CH_NINE, CH_NINE, CH_NINE, CH_NINE,
        CH_NINE, CH_NINE, CH_NINE, CH_NINE, CH_NINE, CH_NUL,
        8'h3F, 8'h80
    };

    relative_decimal_int_parser_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .ch           (ch),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .value        (value),
        .had_digits   (had_digits),
        .was_relative (was_relative),
        .chars_used   (chars_used),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    // Result side: check each transfer, then pick the stall for the next cycle.
    // Outputs are read right after the edge, so they are the pre-edge values.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(value, had_digits, was_relative, chars_used);
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog: any transfer on any channel counts as progress.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Pacing profiles: receiver-heavy stalls, sender-heavy gaps, then full rate.
    task automatic set_pacing(input int profile);
        case (profile)
            0:       begin send_gap_pct = 28; recv_stall_pct = 49; end
            1:       begin send_gap_pct = 49; recv_stall_pct = 28; end
            default: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // Offer one character and hold it until the transfer; in_valid stays high on
    // return so back-to-back characters never lower and raise it in one step.
    task automatic send_char(input logic [CHAR_W-1:0] c);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ch       <= c;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        sb.note_char(c);
        chars_sent++;
    endtask

    // Drop valid, wait for every predicted result, then let the pipeline drain.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending_count() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all three registers back to back; valid drops only after the last one.
    task automatic write_config(input logic signed [VALUE_W-1:0] lo,
                                input logic signed [VALUE_W-1:0] mid,
                                input logic signed [VALUE_W-1:0] hi);
        logic [CFG_IDX_W-1:0] idx [3];
        logic [VALUE_W-1:0]   data [3];
        idx[0] = CFG_MIN_VALUE;     data[0] = lo;
        idx[1] = CFG_DEFAULT_VALUE; data[1] = mid;
        idx[2] = CFG_MAX_VALUE;     data[2] = hi;
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= data[i];
            @(posedge clk);
            while (cfg_ready !== 1'b1)
                @(posedge clk);
            sb.write_reg(idx[i], data[i]);
            cfg_writes++;
        end
        cfg_valid <= 1'b0;
    endtask

    // Non-digit below '@' and not NUL, weighted toward signs and blanks.
    function automatic logic [CHAR_W-1:0] random_skip_char();
        int unsigned      r;
        logic [CHAR_W-1:0] c;
        r = $urandom_range(9);
        if (r < 2)
            return CH_PLUS;
        if (r < 4)
            return CH_MINUS;
        if (r < 5)
            return 8'h20;
        do
            c = 8'($urandom_range(1, 63));
        while (c >= CH_ZERO && c <= CH_NINE);
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] random_high_char();
        return 8'($urandom_range(8'h40, 8'hFF));
    endfunction

    function automatic logic [CHAR_W-1:0] random_terminator();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 35)
            return CH_NUL;
        if (r < 75)
            return random_skip_char();
        return random_high_char();
    endfunction

    // Digits of a number: mostly short random runs, sometimes a boundary magnitude.
    task automatic send_digits();
        longint unsigned boundary_mags [7] = '{
            64'd0, 64'd2147483647, 64'd2147483648, 64'd4294967295, 64'd4294967296,
            64'd99999999999, 64'd999999999999
        };
        string text;
        if ($urandom_range(4) == 0)
        begin
            text = $sformatf("%0d", boundary_mags[$urandom_range(6)]);
            for (int i = 0; i < text.len(); i++)
                send_char(text[i]);
        end
        else
        begin
            repeat ($urandom_range(1, 10))
                send_char(CH_ZERO + 8'($urandom_range(9)));
        end
    endtask

    // One random stretch: mostly well-formed numbers, some digit-free parses, some noise.
    task automatic send_token();
        int unsigned pick;
        pick = $urandom_range(999);
        if (pick < 650)
        begin
            repeat ($urandom_range(3))
                send_char(random_skip_char());
            send_digits();
            send_char(random_terminator());
        end
        else if (pick < 800)
        begin
            repeat ($urandom_range(1, 3))
                send_char(random_skip_char());
            send_char($urandom_range(1) ? CH_NUL : random_high_char());
        end
        else
        begin
            repeat ($urandom_range(1, 4))
                send_char(8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        logic signed [VALUE_W-1:0] lo, mid, hi;
        int unsigned               phase_end;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        ch        <= CH_NUL;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_MIN_VALUE;
        cfg_data  <= '0;
        chars_sent = 0;
        cfg_writes = 0;
        set_pacing(0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed characters run on the reset register values.
        foreach (directed_text[i])
            send_char(directed_text[i]);
        settle();

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            set_pacing(phase / 3);
            case (phase)
                0: begin lo = INT_LO; mid = 0;      hi = INT_HI; end
                1: begin lo = INT_LO; mid = INT_HI; hi = INT_HI; end
                2: begin lo = INT_LO; mid = INT_LO; hi = INT_HI; end
                3: begin lo = -1000;  mid = 5;      hi = 1000;   end
                // reversed bounds
                4: begin lo = 100;    mid = 0;      hi = -100;   end
                5: begin lo = 0;      mid = -7;     hi = 0;      end
                6: begin lo = $urandom; mid = $urandom; hi = $urandom; end
                7:
                begin
                    lo  = -int'($urandom_range(5000));
                    mid = int'($urandom_range(200)) - 100;
                    hi  = int'($urandom_range(5000));
                end
                default: begin lo = INT_HI; mid = INT_LO; hi = INT_LO; end
            endcase
            write_config(lo, mid, hi);

            // Long runs push chars_used into saturation in each phase of the parse.
            if (phase == 2)
            begin
                repeat (260) send_char(random_skip_char());
                send_char(CH_NUL);
            end
            if (phase == 6)
            begin
                repeat (260) send_char(CH_ZERO + 8'($urandom_range(9)));
                send_char(random_skip_char());
            end

            phase_end = chars_sent + PHASE_CHARS;
            while (chars_sent < phase_end)
                send_token();
            // Close any open parse so no state crosses the next register write.
            send_char(CH_NUL);
            settle();
        end

        $display("Covered %0d characters under %0d register settings and three pacing profiles.",
                 chars_sent, NUM_PHASES + 1);
        $display("Compared %0d parse results after %0d register writes.",
                 sb.results_checked, cfg_writes);
        if (sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
